// ----- rtl/core/sdspi_pkg.sv -----
// Shared types and constants for the SPI-mode SD card block read engine.
// No dependencies.
`timescale 1ns / 1ps

package sdspi_pkg;

    localparam int COMMAND_BYTES_DEF  = 7;
    localparam int CRC_BYTES_DEF      = 2;
    localparam int TRAILER_CLOCKS_DEF = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_WAKE  = 2'd2;

    localparam logic [1:0] REG_WAKE  = 2'd0;
    localparam logic [1:0] REG_RESP  = 2'd1;
    localparam logic [1:0] REG_TOKEN = 2'd2;
    localparam logic [1:0] REG_BLOCK = 2'd3;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_RESPONSE  = 3'd1;
    localparam logic [2:0] KIND_TOKEN     = 3'd2;
    localparam logic [2:0] KIND_DATA      = 3'd3;
    localparam logic [2:0] KIND_CRC       = 3'd4;
    localparam logic [2:0] KIND_RESP_TO   = 3'd5;
    localparam logic [2:0] KIND_TOKEN_TO  = 3'd6;

    // One input item as classified by the front end.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  command_byte;
        logic [31:0] argument;
        logic [7:0]  crc_byte;
        logic        read_block;
        logic        miso;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       mosi;
        logic       chip_select;
        logic       clock_active;
        logic [2:0] result_kind;
        logic [7:0] result_byte;
        logic       last;
        logic       busy_res;
    } result_t;

endpackage

// ----- rtl/core/sdspi_fifo.sv -----
// Small queue of registers used between the engine's parts.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module sdspi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_rd |=> full)
        else $error("full queue lost its contents");
    a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (AW+1)'(1)) && do_rd && !do_wr |=> empty)
        else $error("queue not empty after last read");
`endif

endmodule

// ----- rtl/core/sdspi_front.sv -----
// Front end: takes input transactions and classifies requests for the engine.
// Depends on sdspi_pkg and sdspi_fifo.
`timescale 1ns / 1ps

module sdspi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            opcode,
    input  logic [7:0]            command_byte,
    input  logic [31:0]           argument,
    input  logic [7:0]            crc_byte,
    input  logic                  read_block,
    input  logic                  miso,
    output logic                  item_valid,
    input  logic                  item_take,
    output sdspi_pkg::item_t      item
);
    import sdspi_pkg::*;

    item_t in_item;
    logic  q_empty;

    // Codes beyond the defined ones act as a plain clock tick.
    always_comb
    begin
        in_item.opcode       = (opcode == OP_CMD || opcode == OP_WAKE) ? opcode : OP_TICK;
        in_item.command_byte = command_byte;
        in_item.argument     = argument;
        in_item.crc_byte     = crc_byte;
        in_item.read_block   = read_block;
        in_item.miso         = miso;
    end

    sdspi_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_item),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (item),
        .empty   (q_empty)
    );

    assign item_valid = !q_empty;

`ifndef SYNTHESIS
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("item taken from empty queue");
    a_op_clean: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> item.opcode != 2'd3)
        else $error("unclassified opcode queued");
    a_push_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> item_valid)
        else $error("accepted item missing");
`endif

endmodule

// ----- rtl/core/sdspi_engine.sv -----
// Back end: the SPI transaction state machine, one tick per item.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps

module sdspi_engine #(
    parameter int COMMAND_BYTES  = sdspi_pkg::COMMAND_BYTES_DEF,
    parameter int CRC_BYTES      = sdspi_pkg::CRC_BYTES_DEF,
    parameter int TRAILER_CLOCKS = sdspi_pkg::TRAILER_CLOCKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    input  logic                  item_valid,
    output logic                  item_take,
    input  sdspi_pkg::item_t      item,
    output logic                  res_valid,
    input  logic                  res_full,
    output sdspi_pkg::result_t    res
);
    import sdspi_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAKE  = 3'd1;
    localparam logic [2:0] PH_SEND  = 3'd2;
    localparam logic [2:0] PH_RESP  = 3'd3;
    localparam logic [2:0] PH_TOKEN = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CRC   = 3'd6;
    localparam logic [2:0] PH_TRAIL = 3'd7;

    localparam int TXW = COMMAND_BYTES * 8;
    localparam logic [5:0] SEND_BITS = 6'(TXW);

    logic [7:0]     wake_clocks_reg, response_wait_reg;
    logic [9:0]     token_wait_reg;
    logic [12:0]    block_length_reg;

    logic [2:0]     phase_reg, phase_next;
    logic [TXW-1:0] tx_reg, tx_next;
    logic [7:0]     rx_reg, rx_next;
    logic [5:0]     bit_reg, bit_next;
    logic [12:0]    byte_reg, byte_next;
    logic [9:0]     wait_reg, wait_next;
    logic           rdp_reg, rdp_next;

    logic [7:0]     rx_sh;
    logic [5:0]     bit_inc;
    logic           byte_done;
    logic [9:0]     wait_inc;
    logic [12:0]    byte_inc;
    logic [9:0]     resp_lim, token_lim;
    logic [2:0]     ph_end;

    assign item_take = item_valid && !res_full;
    assign res_valid = item_take;

    assign rx_sh     = {rx_reg[6:0], item.miso};
    assign bit_inc   = bit_reg + 6'd1;
    assign byte_done = (bit_inc >= 6'd8);
    assign wait_inc  = wait_reg + 10'd1;
    assign byte_inc  = byte_reg + 13'd1;
    // A zero wait register behaves as one.
    assign resp_lim  = (response_wait_reg == '0) ? 10'd1 : {2'b00, response_wait_reg};
    assign token_lim = (token_wait_reg == '0) ? 10'd1 : token_wait_reg;
    assign ph_end    = (TRAILER_CLOCKS > 0) ? PH_TRAIL : PH_IDLE;

    always_comb
    begin
        phase_next = phase_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        wait_next  = wait_reg;
        rdp_next   = rdp_reg;
        res        = '{mosi: 1'b1, chip_select: 1'b1, clock_active: 1'b0,
                       result_kind: KIND_NONE, result_byte: 8'h00,
                       last: 1'b0, busy_res: 1'b0};
        if (phase_reg == PH_IDLE)
        begin
            if (item.opcode == OP_CMD)
            begin
                tx_next = TXW'({8'hFF, item.command_byte, item.argument, item.crc_byte});
                rdp_next   = item.read_block;
                bit_next   = '0;
                byte_next  = '0;
                wait_next  = '0;
                rx_next    = 8'hFF;
                phase_next = PH_SEND;
                res.chip_select = 1'b0;
                res.busy_res    = 1'b1;
            end
            else if (item.opcode == OP_WAKE && wake_clocks_reg != '0)
            begin
                wait_next    = {2'b00, wake_clocks_reg};
                phase_next   = PH_WAKE;
                res.busy_res = 1'b1;
            end
        end
        else
        begin
            res.busy_res     = 1'b1;
            res.clock_active = 1'b1;
            res.chip_select  = (phase_reg == PH_WAKE || phase_reg == PH_TRAIL);
            unique case (phase_reg)
                PH_WAKE:
                begin
                    wait_next = wait_reg - 10'd1;
                    if (wait_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_SEND:
                begin
                    res.mosi = tx_reg[TXW-1];
                    tx_next  = {tx_reg[TXW-2:0], 1'b1};
                    bit_next = bit_inc;
                    if (bit_inc >= SEND_BITS)
                    begin
                        bit_next   = '0;
                        wait_next  = '0;
                        phase_next = PH_RESP;
                    end
                end
                PH_RESP:
                begin
                    if (bit_reg == '0)
                    begin
                        if (!item.miso)
                        begin
                            rx_next  = 8'h00;
                            bit_next = 6'd1;
                        end
                        else
                        begin
                            wait_next = wait_inc;
                            if (wait_inc >= resp_lim)
                            begin
                                res.result_kind = KIND_RESP_TO;
                                res.last        = 1'b1;
                                phase_next      = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        rx_next  = rx_sh;
                        bit_next = byte_done ? 6'd0 : bit_inc;
                        if (byte_done)
                        begin
                            res.result_kind = KIND_RESPONSE;
                            res.result_byte = rx_sh;
                            if (rdp_reg)
                            begin
                                wait_next  = '0;
                                rx_next    = 8'hFF;
                                phase_next = PH_TOKEN;
                            end
                            else
                            begin
                                res.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                PH_TOKEN:
                begin
                    rx_next  = rx_sh;
                    bit_next = byte_done ? 6'd0 : bit_inc;
                    if (byte_done)
                    begin
                        if (rx_sh != 8'hFF)
                        begin
                            res.result_kind = KIND_TOKEN;
                            res.result_byte = rx_sh;
                            byte_next       = '0;
                            phase_next      = PH_DATA;
                        end
                        else
                        begin
                            wait_next = wait_inc;
                            if (wait_inc >= token_lim)
                            begin
                                res.result_kind = KIND_TOKEN_TO;
                                res.last        = 1'b1;
                                wait_next       = '0;
                                phase_next      = ph_end;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    rx_next  = rx_sh;
                    bit_next = byte_done ? 6'd0 : bit_inc;
                    if (byte_done)
                    begin
                        res.result_kind = KIND_DATA;
                        res.result_byte = rx_sh;
                        byte_next       = byte_inc;
                        // A zero block length wraps to the full counter range.
                        if (byte_inc == block_length_reg)
                        begin
                            byte_next = '0;
                            if (CRC_BYTES > 0)
                            begin
                                phase_next = PH_CRC;
                            end
                            else
                            begin
                                res.last   = 1'b1;
                                wait_next  = '0;
                                phase_next = ph_end;
                            end
                        end
                    end
                end
                PH_CRC:
                begin
                    rx_next  = rx_sh;
                    bit_next = byte_done ? 6'd0 : bit_inc;
                    if (byte_done)
                    begin
                        res.result_kind = KIND_CRC;
                        res.result_byte = rx_sh;
                        byte_next       = byte_inc;
                        if (byte_inc >= 13'(CRC_BYTES))
                        begin
                            byte_next  = '0;
                            res.last   = 1'b1;
                            wait_next  = '0;
                            phase_next = ph_end;
                        end
                    end
                end
                default:
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= 10'(TRAILER_CLOCKS))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tx_reg    <= '1;
            rx_reg    <= 8'hFF;
            bit_reg   <= '0;
            byte_reg  <= '0;
            wait_reg  <= '0;
            rdp_reg   <= 1'b0;
        end
        else if (item_take)
        begin
            phase_reg <= phase_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            wait_reg  <= wait_next;
            rdp_reg   <= rdp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_clocks_reg   <= 8'd74;
            response_wait_reg <= 8'd16;
            token_wait_reg    <= 10'd256;
            block_length_reg  <= 13'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAKE:  wake_clocks_reg   <= cfg_data[7:0];
                REG_RESP:  response_wait_reg <= cfg_data[7:0];
                REG_TOKEN: token_wait_reg    <= cfg_data[9:0];
                REG_BLOCK: block_length_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= SEND_BITS)
        else $error("bit counter out of range");
    a_last_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.result_kind != KIND_NONE)
        else $error("last flag on an empty result");
    a_cs_low_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && phase_reg >= PH_SEND && phase_reg <= PH_CRC |-> !res.chip_select)
        else $error("chip select high inside a transaction");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_take |=> $stable(phase_reg))
        else $error("state moved without an item");
`endif

endmodule

// ----- rtl/core/sd_spi_command_block_read.sv -----
// SPI-mode SD card command and single block read engine.
//
// Input channel: one transaction per SCLK tick slot (push/full). opcode 0 is a
// plain tick carrying the sampled miso bit, opcode 1 starts a command (with
// command_byte, argument, crc_byte, read_block), opcode 2 sends wake clocks.
// Output channel (empty/pop): exactly one result per input transaction, with
// the mosi, chip_select and clock_active levels for that tick and any byte
// received (result_kind, result_byte, last, busy_res).
// An accepted transaction enters a two-entry input queue; the engine takes it
// when the output queue has room and writes its result into the two-entry
// output queue, from which it shows on the output ports and can be popped.
// Throughput: one transaction per cycle while the output queue is not full.
// When pop stalls, the output queue fills, the engine holds, and full rises
// once the input queue is full too; nothing is lost.
// Reset clears the engine to idle, loads default registers and empties both
// queues. Configuration goes through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Depends on sdspi_pkg, sdspi_fifo, sdspi_front and sdspi_engine.
`timescale 1ns / 1ps

module sd_spi_command_block_read #(
    parameter int COMMAND_BYTES  = sdspi_pkg::COMMAND_BYTES_DEF,
    parameter int CRC_BYTES      = sdspi_pkg::CRC_BYTES_DEF,
    parameter int TRAILER_CLOCKS = sdspi_pkg::TRAILER_CLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [7:0]  command_byte,
    input  logic [31:0] argument,
    input  logic [7:0]  crc_byte,
    input  logic        read_block,
    input  logic        miso,
    output logic        empty,
    input  logic        pop,
    output logic        mosi,
    output logic        chip_select,
    output logic        clock_active,
    output logic [2:0]  result_kind,
    output logic [7:0]  result_byte,
    output logic        last,
    output logic        busy_res
);
    import sdspi_pkg::*;

    item_t   item;
    result_t res, out_res;
    logic    item_valid, item_take, res_valid, res_full;

    sdspi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .command_byte (command_byte),
        .argument     (argument),
        .crc_byte     (crc_byte),
        .read_block   (read_block),
        .miso         (miso),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item         (item)
    );

    sdspi_engine #(
        .COMMAND_BYTES  (COMMAND_BYTES),
        .CRC_BYTES      (CRC_BYTES),
        .TRAILER_CLOCKS (TRAILER_CLOCKS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (res_valid),
        .res_full   (res_full),
        .res        (res)
    );

    sdspi_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign mosi         = out_res.mosi;
    assign chip_select  = out_res.chip_select;
    assign clock_active = out_res.clock_active;
    assign result_kind  = out_res.result_kind;
    assign result_byte  = out_res.result_byte;
    assign last         = out_res.last;
    assign busy_res     = out_res.busy_res;

endmodule
